### rtl/rbht_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rbht_pkg
// Types and constants for the button rectangle hit-test table.
// ----------------------------------------------------------------------------
package rbht_pkg;

	localparam int MAX_BUTTONS_DEF = 16;

	localparam int KEY_W  = 16;
	localparam int PIX_W  = 12;
	localparam int SCR_W  = 13;
	localparam int Q_W    = 16;
	localparam int DIFF_W = 14;
	localparam int NUM_W  = 27;
	localparam int MAG_W  = 26;
	localparam int DEN2_W = 14;
	localparam int STEP_W = 4;

	localparam logic [SCR_W-1:0] HALF_W_REF = 13'd960;
	localparam logic [SCR_W-1:0] HALF_H_REF = 13'd540;
	localparam logic [SCR_W-1:0] SCR_MIN    = 13'd2;
	localparam logic [SCR_W-1:0] SCR_W_RST  = 13'd1920;
	localparam logic [SCR_W-1:0] SCR_H_RST  = 13'd1080;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 2'd1;

	localparam logic [1:0] MODE_FRAME   = 2'd0;
	localparam logic [1:0] MODE_PLACE   = 2'd1;
	localparam logic [1:0] MODE_PRESS   = 2'd2;
	localparam logic [1:0] MODE_RELEASE = 2'd3;

	localparam logic [1:0] OP_LEFT   = 2'd0;
	localparam logic [1:0] OP_RIGHT  = 2'd1;
	localparam logic [1:0] OP_BOTTOM = 2'd2;
	localparam logic [1:0] OP_TOP    = 2'd3;

	typedef struct packed {
		logic [KEY_W-1:0]      key;
		logic signed [Q_W-1:0] left;
		logic signed [Q_W-1:0] right;
		logic signed [Q_W-1:0] bottom;
		logic signed [Q_W-1:0] top;
	} tbl_entry_t;

endpackage
`default_nettype wire

### rtl/rect_button_hit_test_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rect_button_hit_test_table
// Table of button rectangles with key lookup, append and point hit test.
// ----------------------------------------------------------------------------
// Input beats are taken on in_valid/in_stall; one result beat (hit_flag,
// table_full) leaves per input beat on out_valid/out_stall. in_stall stays
// high while an item is worked. Config writes (cfg_index 0 screen width,
// 1 screen height) are always ready; write them only while the block is idle.
// A frame start goes straight to the finish step. A place walks the table for
// its key; a new key then gets four divisions unless the table is full. A press
// or release runs two divisions and then walks the entries up to the first hit.
// All divisions share the one-bit-per-cycle divider; the entry walk reads each
// entry through the registered table read port. The next item can be taken in
// the cycle in which the result beat is first presented, at the earliest.
// Reset clears the table count, active marks, pressed latches and out_valid.
// A stalled result waits in the output register; the next item may be taken
// meanwhile and finishes once that register is free.
// ----------------------------------------------------------------------------
module rect_button_hit_test_table
	import rbht_pkg::*;
#(
	parameter int MAX_BUTTONS = MAX_BUTTONS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,

	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [SCR_W-1:0]     cfg_data,

	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic [1:0]           mode,
	input  wire logic [KEY_W-1:0]     button_key,
	input  wire logic [PIX_W-1:0]     rect_x,
	input  wire logic [PIX_W-1:0]     rect_y,
	input  wire logic [PIX_W-1:0]     rect_width,
	input  wire logic [PIX_W-1:0]     rect_height,
	input  wire logic [PIX_W-1:0]     point_x,
	input  wire logic [PIX_W-1:0]     point_y,

	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic                      hit_flag,
	output logic                      table_full
);

	localparam int IDX_W = (MAX_BUTTONS > 1) ? $clog2(MAX_BUTTONS) : 1;
	localparam int CNT_W = $clog2(MAX_BUTTONS + 1);

	localparam logic [2:0] ST_IDLE     = 3'd0;
	localparam logic [2:0] ST_DIV_LD   = 3'd1;
	localparam logic [2:0] ST_DIV_RUN  = 3'd2;
	localparam logic [2:0] ST_DIV_END  = 3'd3;
	localparam logic [2:0] ST_SCAN_RD  = 3'd4;
	localparam logic [2:0] ST_SCAN_CMP = 3'd5;
	localparam logic [2:0] ST_APPEND   = 3'd6;
	localparam logic [2:0] ST_FIN      = 3'd7;

	logic [2:0]             state_q;
	logic [SCR_W-1:0]       scr_w_q, scr_h_q;

	logic [1:0]             mode_q;
	logic [KEY_W-1:0]       key_q;
	logic [PIX_W-1:0]       rx_q, ry_q, rw_q, rh_q, px_in_q, py_in_q;

	logic [CNT_W-1:0]       count_q;
	logic [CNT_W-1:0]       idx_q;
	logic [1:0]             op_q;
	logic [MAX_BUTTONS-1:0] act_q, prs_q;
	logic                   hit_q, full_q;
	logic                   out_valid_q, out_hit_q, out_full_q;

	logic signed [Q_W-1:0]  res_q [4];

	logic                   div_neg_q, div_ovf_q;
	logic [DEN2_W-1:0]      div_d2_q, div_r_q;
	logic [Q_W-1:0]         div_m_q, div_qt_q;
	logic [STEP_W-1:0]      step_q;

	tbl_entry_t             tbl_mem [MAX_BUTTONS];
	tbl_entry_t             rd_q;
	tbl_entry_t             wr_entry;
	logic                   mem_we;

	logic                   accept, is_query, last_op, out_free;
	logic [SCR_W-1:0]       w_eff, h_eff, den;
	logic [DIFF_W-1:0]      diff;
	logic [NUM_W-1:0]       n2;
	logic [MAG_W-1:0]       mag;
	logic [DEN2_W-1:0]      d2;
	logic [DEN2_W:0]        trial;
	logic                   trial_ge;
	logic [Q_W-1:0]         quo;
	logic signed [Q_W-1:0]  div_res;
	logic                   key_match, cross_y, odd_x, rect_hit;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != ST_IDLE);
	assign accept    = in_valid && !in_stall;
	assign is_query  = mode_q[1];
	assign last_op   = is_query ? (op_q == OP_RIGHT) : (op_q == OP_TOP);
	assign out_free  = !out_valid_q || !out_stall;

	assign out_valid  = out_valid_q;
	assign hit_flag   = out_hit_q;
	assign table_full = out_full_q;

	// divider operand select
	always_comb begin
		w_eff = (scr_w_q < SCR_MIN) ? SCR_MIN : scr_w_q;
		h_eff = (scr_h_q < SCR_MIN) ? SCR_MIN : scr_h_q;
		diff  = '0;
		den   = HALF_W_REF;
		if (is_query) begin
			if (op_q == OP_LEFT) begin
				diff = {1'b0, px_in_q, 1'b0} - {1'b0, w_eff};
				den  = w_eff;
			end else begin
				diff = {1'b0, h_eff} - {1'b0, py_in_q, 1'b0};
				den  = h_eff;
			end
		end else begin
			unique case (op_q)
				OP_LEFT: begin
					diff = {2'b00, rx_q} - {1'b0, HALF_W_REF};
					den  = HALF_W_REF;
				end
				OP_RIGHT: begin
					diff = {1'b0, {1'b0, rx_q} + {1'b0, rw_q}} - {1'b0, HALF_W_REF};
					den  = HALF_W_REF;
				end
				OP_BOTTOM: begin
					diff = {2'b00, ry_q} - {1'b0, HALF_H_REF};
					den  = HALF_H_REF;
				end
				OP_TOP: begin
					diff = {1'b0, {1'b0, ry_q} + {1'b0, rh_q}} - {1'b0, HALF_H_REF};
					den  = HALF_H_REF;
				end
				default: begin
					diff = '0;
					den  = HALF_W_REF;
				end
			endcase
		end
		n2  = {diff[DIFF_W-1], diff, 12'b0} + {{(NUM_W-SCR_W){1'b0}}, den};
		mag = n2[NUM_W-1] ? ~n2[MAG_W-1:0] : n2[MAG_W-1:0];
		d2  = {den, 1'b0};
	end

	// one restoring step
	assign trial    = {div_r_q, div_m_q[Q_W-1]};
	assign trial_ge = (trial >= {1'b0, div_d2_q});
	assign quo      = div_ovf_q ? {1'b0, {(Q_W-1){1'b1}}} : div_qt_q;
	assign div_res  = div_neg_q ? $signed(~quo) : $signed(quo);

	// entry compare
	assign key_match = (rd_q.key == key_q);
	assign cross_y   = (res_q[1] <= rd_q.bottom) != (res_q[1] <= rd_q.top);
	assign odd_x     = (res_q[0] <= rd_q.left) != (res_q[0] <= rd_q.right);
	assign rect_hit  = cross_y && odd_x;

	assign mem_we          = (state_q == ST_APPEND);
	assign wr_entry.key    = key_q;
	assign wr_entry.left   = res_q[OP_LEFT];
	assign wr_entry.right  = res_q[OP_RIGHT];
	assign wr_entry.bottom = res_q[OP_BOTTOM];
	assign wr_entry.top    = res_q[OP_TOP];

	always_ff @(posedge clk) begin
		if (mem_we) begin
			tbl_mem[count_q[IDX_W-1:0]] <= wr_entry;
		end
		rd_q <= tbl_mem[idx_q[IDX_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scr_w_q <= SCR_W_RST;
			scr_h_q <= SCR_H_RST;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == CFG_SCREEN_WIDTH) begin
				scr_w_q <= cfg_data;
			end else if (cfg_index == CFG_SCREEN_HEIGHT) begin
				scr_h_q <= cfg_data;
			end
		end
	end

	// payload and datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q  <= mode;
			key_q   <= button_key;
			rx_q    <= rect_x;
			ry_q    <= rect_y;
			rw_q    <= rect_width;
			rh_q    <= rect_height;
			px_in_q <= point_x;
			py_in_q <= point_y;
		end
		if (state_q == ST_DIV_LD) begin
			div_neg_q <= n2[NUM_W-1];
			div_ovf_q <= ({{(DEN2_W-11){1'b0}}, mag[MAG_W-1:15]} >= d2);
			div_d2_q  <= d2;
			div_r_q   <= {{(DEN2_W-10){1'b0}}, mag[MAG_W-1:16]};
			div_m_q   <= mag[Q_W-1:0];
			div_qt_q  <= '0;
		end
		if (state_q == ST_DIV_RUN) begin
			div_r_q  <= trial_ge ? DEN2_W'(trial - {1'b0, div_d2_q}) : trial[DEN2_W-1:0];
			div_m_q  <= {div_m_q[Q_W-2:0], 1'b0};
			div_qt_q <= {div_qt_q[Q_W-2:0], trial_ge};
		end
		if (state_q == ST_DIV_END) begin
			res_q[op_q] <= div_res;
		end
		if (out_valid_q == 1'b0 || !out_stall) begin
			if (state_q == ST_FIN) begin
				out_hit_q  <= hit_q;
				out_full_q <= full_q;
			end
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			idx_q       <= '0;
			op_q        <= OP_LEFT;
			step_q      <= '0;
			act_q       <= '0;
			prs_q       <= '0;
			hit_q       <= 1'b0;
			full_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_FIN && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						hit_q  <= 1'b0;
						full_q <= 1'b0;
						idx_q  <= '0;
						op_q   <= OP_LEFT;
						unique case (mode)
							MODE_FRAME: begin
								act_q   <= '0;
								state_q <= ST_FIN;
							end
							MODE_PLACE: state_q <= ST_SCAN_RD;
							default:    state_q <= ST_DIV_LD;
						endcase
					end
				end
				ST_DIV_LD: begin
					step_q  <= '0;
					state_q <= ST_DIV_RUN;
				end
				ST_DIV_RUN: begin
					step_q <= step_q + 1'b1;
					if (step_q == {STEP_W{1'b1}}) begin
						state_q <= ST_DIV_END;
					end
				end
				ST_DIV_END: begin
					op_q <= op_q + 1'b1;
					if (!last_op) begin
						state_q <= ST_DIV_LD;
					end else if (is_query) begin
						idx_q   <= '0;
						state_q <= ST_SCAN_RD;
					end else begin
						state_q <= ST_APPEND;
					end
				end
				ST_SCAN_RD: begin
					if (idx_q == count_q) begin
						if (is_query) begin
							state_q <= ST_FIN;
						end else if (count_q == CNT_W'(MAX_BUTTONS)) begin
							full_q  <= 1'b1;
							state_q <= ST_FIN;
						end else begin
							op_q    <= OP_LEFT;
							state_q <= ST_DIV_LD;
						end
					end else begin
						state_q <= ST_SCAN_CMP;
					end
				end
				ST_SCAN_CMP: begin
					if (!is_query) begin
						if (key_match) begin
							act_q[idx_q[IDX_W-1:0]] <= 1'b1;
							hit_q                   <= prs_q[idx_q[IDX_W-1:0]];
							prs_q[idx_q[IDX_W-1:0]] <= 1'b0;
							state_q                 <= ST_FIN;
						end else begin
							idx_q   <= idx_q + 1'b1;
							state_q <= ST_SCAN_RD;
						end
					end else if (rect_hit) begin
						if (mode_q == MODE_PRESS) begin
							hit_q <= 1'b1;
						end else if (act_q[idx_q[IDX_W-1:0]]) begin
							prs_q[idx_q[IDX_W-1:0]] <= 1'b1;
							hit_q                   <= 1'b1;
						end
						state_q <= ST_FIN;
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= ST_SCAN_RD;
					end
				end
				ST_APPEND: begin
					act_q[count_q[IDX_W-1:0]] <= 1'b1;
					prs_q[count_q[IDX_W-1:0]] <= 1'b0;
					count_q                   <= count_q + 1'b1;
					state_q                   <= ST_FIN;
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_BUTTONS))
		else $error("entry count beyond table depth");

	a_append_room: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_APPEND) |-> (count_q < CNT_W'(MAX_BUTTONS)))
		else $error("append into full table");

	a_scan_index: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN_CMP) |-> (idx_q < count_q))
		else $error("entry walk past table end");

	a_out_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == ST_FIN))
		else $error("result beat not from finish step");

	a_full_no_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_full_q) |-> !out_hit_q)
		else $error("full table beat reports a hit");
`endif

endmodule
`default_nettype wire

### verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for rect_button_hit_test_table. A local model of the
// button table predicts hit_flag and table_full for every accepted item, and
// every result beat is checked in order against it. Directed items cover an
// empty table, the coordinate extremes, overlapping rectangles, releases on
// inactive entries and clamped screen sizes. Random frames of place, press
// and release traffic follow, with screen size changes and random idling on
// both sides. The run closes with a full table.
// ----------------------------------------------------------------------------
module testbench
	import rbht_pkg::*;
();

	localparam int MAX_BTN     = MAX_BUTTONS_DEF;
	localparam int POOL_N      = 24;
	localparam int CYCLE_LIMIT = 1000000;

	typedef struct {
		logic [1:0]       mode;
		logic [KEY_W-1:0] key;
		logic [PIX_W-1:0] rx;
		logic [PIX_W-1:0] ry;
		logic [PIX_W-1:0] rw;
		logic [PIX_W-1:0] rh;
		logic [PIX_W-1:0] px;
		logic [PIX_W-1:0] py;
	} ui_event_t;

	typedef struct {
		logic       hit;
		logic       full;
		logic [1:0] mode;
		int         seq;
	} answer_t;

	typedef struct {
		int x;
		int y;
		int w;
		int h;
	} rect_px_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [SCR_W-1:0]     cfg_data;
	logic                 in_valid;
	logic                 in_stall;
	logic [1:0]           mode;
	logic [KEY_W-1:0]     button_key;
	logic [PIX_W-1:0]     rect_x;
	logic [PIX_W-1:0]     rect_y;
	logic [PIX_W-1:0]     rect_width;
	logic [PIX_W-1:0]     rect_height;
	logic [PIX_W-1:0]     point_x;
	logic [PIX_W-1:0]     point_y;
	logic                 out_valid;
	logic                 out_stall;
	logic                 hit_flag;
	logic                 table_full;

	// local copy of the button table and screen setting
	tbl_entry_t       btn_tbl[MAX_BTN];
	rect_px_t         btn_px[MAX_BTN];
	bit               btn_active[MAX_BTN];
	bit               btn_latched[MAX_BTN];
	int               n_entries;
	logic [SCR_W-1:0] scr_w;
	logic [SCR_W-1:0] scr_h;

	answer_t          answers_due[$];
	answer_t          want;
	logic [KEY_W-1:0] key_pool[POOL_N];
	int               items_sent = 0;
	int               err_count = 0;
	int               cycle_count = 0;
	int               stall_left = 0;
	bit               idle_en = 1'b0;

	rect_button_hit_test_table dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.mode        (mode),
		.button_key  (button_key),
		.rect_x      (rect_x),
		.rect_y      (rect_y),
		.rect_width  (rect_width),
		.rect_height (rect_height),
		.point_x     (point_x),
		.point_y     (point_y),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.hit_flag    (hit_flag),
		.table_full  (table_full)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// result side stalls in bursts
	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
		end else if (idle_en && $urandom_range(0, 7) == 0) begin
			out_stall  <= 1'b1;
			stall_left <= $urandom_range(0, 14);
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (answers_due.size() == 0) begin
				err_count++;
				if (err_count <= 10)
					$display("unexpected result beat: hit_flag=%b table_full=%b",
						hit_flag, table_full);
			end else begin
				want = answers_due.pop_front();
				if (hit_flag !== want.hit || table_full !== want.full) begin
					err_count++;
					if (err_count <= 10)
						$display("mismatch item %0d mode %0d: expected hit=%b full=%b, got hit=%b full=%b",
							want.seq, want.mode, want.hit, want.full, hit_flag, table_full);
				end
			end
		end
	end

	// round to nearest, ties up, saturated to q4.11
	function automatic int to_q11(longint num, longint den);
		longint n2, d2, q;
		n2 = 2 * num + den;
		d2 = 2 * den;
		q = n2 / d2;
		if (n2 % d2 != 0 && n2 < 0)
			q--;
		if (q > 32767)
			q = 32767;
		if (q < -32768)
			q = -32768;
		return int'(q);
	endfunction

	function automatic answer_t compute_answer(ui_event_t ev);
		answer_t a;
		bit      found;
		int      slot;
		longint  hx, hy, w, h;
		int      qx, qy;
		a.hit = 1'b0;
		a.full = 1'b0;
		a.mode = ev.mode;
		a.seq = items_sent;
		found = 1'b0;
		slot = 0;
		hx = longint'(HALF_W_REF);
		hy = longint'(HALF_H_REF);
		w = longint'((scr_w < SCR_MIN) ? SCR_MIN : scr_w);
		h = longint'((scr_h < SCR_MIN) ? SCR_MIN : scr_h);
		case (ev.mode)
		MODE_FRAME: begin
			for (int i = 0; i < MAX_BTN; i++)
				btn_active[i] = 1'b0;
		end
		MODE_PLACE: begin
			for (int i = 0; i < n_entries; i++) begin
				if (btn_tbl[i].key == ev.key) begin
					found = 1'b1;
					slot = i;
				end
			end
			if (!found && n_entries >= MAX_BTN) begin
				a.full = 1'b1;
			end else if (!found) begin
				slot = n_entries;
				btn_tbl[slot].key = ev.key;
				btn_tbl[slot].left = to_q11((longint'(ev.rx) - hx) * 2048, hx);
				btn_tbl[slot].right =
					to_q11((longint'(ev.rx) + longint'(ev.rw) - hx) * 2048, hx);
				btn_tbl[slot].bottom = to_q11((longint'(ev.ry) - hy) * 2048, hy);
				btn_tbl[slot].top =
					to_q11((longint'(ev.ry) + longint'(ev.rh) - hy) * 2048, hy);
				btn_px[slot] = '{int'(ev.rx), int'(ev.ry), int'(ev.rw), int'(ev.rh)};
				btn_latched[slot] = 1'b0;
				n_entries++;
				found = 1'b1;
			end
			if (found) begin
				btn_active[slot] = 1'b1;
				a.hit = btn_latched[slot];
				btn_latched[slot] = 1'b0;
			end
		end
		default: begin
			qx = to_q11((2 * longint'(ev.px) - w) * 2048, w);
			qy = to_q11((h - 2 * longint'(ev.py)) * 2048, h);
			for (int i = 0; i < n_entries; i++) begin
				if (!found
					&& ((qy <= int'($signed(btn_tbl[i].bottom)))
						!= (qy <= int'($signed(btn_tbl[i].top))))
					&& ((qx <= int'($signed(btn_tbl[i].left)))
						!= (qx <= int'($signed(btn_tbl[i].right))))) begin
					found = 1'b1;
					if (ev.mode == MODE_PRESS) begin
						a.hit = 1'b1;
					end else if (btn_active[i]) begin
						btn_latched[i] = 1'b1;
						a.hit = 1'b1;
					end
				end
			end
		end
		endcase
		return a;
	endfunction

	function automatic ui_event_t make_item(logic [1:0] m);
		ui_event_t ev;
		ev.mode = m;
		ev.key = KEY_W'($urandom);
		ev.rx = PIX_W'($urandom);
		ev.ry = PIX_W'($urandom);
		ev.rw = PIX_W'($urandom);
		ev.rh = PIX_W'($urandom);
		ev.px = PIX_W'($urandom);
		ev.py = PIX_W'($urandom);
		return ev;
	endfunction

	function automatic ui_event_t place_item(logic [KEY_W-1:0] k, int x, int y, int w, int h);
		ui_event_t ev;
		ev = make_item(MODE_PLACE);
		ev.key = k;
		ev.rx = PIX_W'(x);
		ev.ry = PIX_W'(y);
		ev.rw = PIX_W'(w);
		ev.rh = PIX_W'(h);
		return ev;
	endfunction

	function automatic ui_event_t point_item(logic [1:0] m, int x, int y);
		ui_event_t ev;
		ev = make_item(m);
		ev.px = PIX_W'(x);
		ev.py = PIX_W'(y);
		return ev;
	endfunction

	// pointer pixel that lands on a given pixel of the 1920x1080 frame
	function automatic ui_event_t aimed(ui_event_t ev, int tx, int ty);
		longint w, h, x, y;
		w = longint'((scr_w < SCR_MIN) ? SCR_MIN : scr_w);
		h = longint'((scr_h < SCR_MIN) ? SCR_MIN : scr_h);
		x = longint'(tx) * w / (2 * longint'(HALF_W_REF));
		y = h - longint'(ty) * h / (2 * longint'(HALF_H_REF));
		if (x > 4095)
			x = 4095;
		if (y < 0)
			y = 0;
		if (y > 4095)
			y = 4095;
		ev.px = PIX_W'(x);
		ev.py = PIX_W'(y);
		return ev;
	endfunction

	function automatic logic [SCR_W-1:0] pick_screen(logic [SCR_W-1:0] usual);
		logic [SCR_W-1:0] v;
		case ($urandom_range(0, 9))
		0: v = SCR_W'($urandom_range(0, 1));
		1: v = SCR_MIN;
		2: v = 13'd4096;
		3: v = 13'd8191;
		4, 5: v = usual;
		default: v = SCR_W'($urandom_range(2, 4096));
		endcase
		return v;
	endfunction

	task automatic send_event(ui_event_t ev);
		int gap;
		if (idle_en && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 15);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		mode        <= ev.mode;
		button_key  <= ev.key;
		rect_x      <= ev.rx;
		rect_y      <= ev.ry;
		rect_width  <= ev.rw;
		rect_height <= ev.rh;
		point_x     <= ev.px;
		point_y     <= ev.py;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		answers_due.insert(answers_due.size(), compute_answer(ev));
		items_sent++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (answers_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_screen(logic [SCR_W-1:0] w, logic [SCR_W-1:0] h);
		cfg_valid <= 1'b1;
		cfg_index <= CFG_SCREEN_WIDTH;
		cfg_data  <= w;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		scr_w = w;
		cfg_index <= CFG_SCREEN_HEIGHT;
		cfg_data  <= h;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		scr_h = h;
		cfg_valid <= 1'b0;
	endtask

	task automatic test_empty_table();
		send_event(make_item(MODE_FRAME));
		send_event(point_item(MODE_PRESS, 0, 0));
		send_event(point_item(MODE_RELEASE, 4095, 4095));
		// zero-size rectangle at the frame center
		send_event(place_item(16'h0000, 960, 540, 0, 0));
		send_event(point_item(MODE_PRESS, 960, 540));
	endtask

	task automatic test_place_and_release();
		send_event(place_item(16'hFFFF, 4095, 4095, 4095, 4095));
		send_event(place_item(16'h1234, 100, 100, 200, 150));
		send_event(place_item(16'h5678, 150, 120, 200, 150));
		send_event(aimed(make_item(MODE_PRESS), 200, 200));
		send_event(make_item(MODE_FRAME));
		send_event(place_item(16'h5678, 0, 0, 10, 10));
		// overlap: first hit in table order is inactive
		send_event(aimed(make_item(MODE_RELEASE), 200, 200));
		send_event(aimed(make_item(MODE_RELEASE), 330, 260));
		send_event(place_item(16'h5678, 0, 0, 0, 0));
		send_event(place_item(16'h5678, 0, 0, 0, 0));
		send_event(place_item(16'h1234, 0, 0, 4095, 4095));
		send_event(point_item(MODE_PRESS, 4095, 0));
		send_event(point_item(MODE_RELEASE, 0, 4095));
	endtask

	task automatic test_screen_sizes();
		logic [SCR_W-1:0] widths[4];
		logic [SCR_W-1:0] heights[4];
		widths = '{13'd0, 13'd1, 13'd8191, SCR_MIN};
		heights = '{13'd1, 13'd0, 13'd4096, 13'd8191};
		drain();
		foreach (widths[i]) begin
			set_screen(widths[i], heights[i]);
			send_event(point_item(MODE_PRESS, 0, 0));
			send_event(point_item(MODE_RELEASE, 4095, 4095));
			drain();
		end
	endtask

	// frame start, a few places, aimed queries, maybe a latch re-place; or one item
	task automatic run_sequence();
		ui_event_t ev;
		int        k, n, last;
		if ($urandom_range(0, 9) < 7) begin
			send_event(make_item(MODE_FRAME));
			n = $urandom_range(1, 4);
			repeat (n) begin
				ev = make_item(MODE_PLACE);
				ev.key = key_pool[$urandom_range(0, POOL_N - 1)];
				if ($urandom_range(0, 3) != 0) begin
					ev.rx = PIX_W'($urandom_range(0, 1900));
					ev.ry = PIX_W'($urandom_range(0, 1060));
					ev.rw = PIX_W'($urandom_range(0, 300));
					ev.rh = PIX_W'($urandom_range(0, 200));
				end
				send_event(ev);
			end
			last = -1;
			n = $urandom_range(1, 5);
			repeat (n) begin
				ev = make_item($urandom_range(0, 1) ? MODE_PRESS : MODE_RELEASE);
				if (n_entries > 0 && $urandom_range(0, 4) != 0) begin
					k = $urandom_range(0, n_entries - 1);
					ev = aimed(ev, btn_px[k].x + $urandom_range(0, btn_px[k].w),
						btn_px[k].y + $urandom_range(0, btn_px[k].h));
					last = k;
				end
				send_event(ev);
			end
			if (last >= 0 && $urandom_range(0, 1)) begin
				ev = make_item(MODE_PLACE);
				ev.key = btn_tbl[last].key;
				send_event(ev);
			end
		end else begin
			ev = make_item(2'($urandom_range(0, 3)));
			if (ev.mode == MODE_PLACE && $urandom_range(0, 1))
				ev.key = key_pool[$urandom_range(0, POOL_N - 1)];
			send_event(ev);
		end
	endtask

	task automatic test_random_traffic(int n_items);
		int stop_at, seg_end;
		stop_at = items_sent + n_items;
		for (int i = 0; i < POOL_N; i++)
			key_pool[i] = (i < n_entries) ? btn_tbl[i].key : KEY_W'($urandom);
		while (items_sent < stop_at) begin
			drain();
			set_screen(pick_screen(SCR_W_RST), pick_screen(SCR_H_RST));
			idle_en <= (stop_at - items_sent > 200) && ($urandom_range(0, 3) != 0);
			seg_end = items_sent + $urandom_range(60, 150);
			while (items_sent < seg_end && items_sent < stop_at)
				run_sequence();
		end
	endtask

	task automatic test_table_full();
		while (n_entries < MAX_BTN)
			send_event(make_item(MODE_PLACE));
		repeat (2) send_event(make_item(MODE_PLACE));
		send_event(place_item(btn_tbl[0].key, 0, 0, 0, 0));
		send_event(aimed(make_item(MODE_RELEASE), btn_px[0].x, btn_px[0].y));
	endtask

	initial begin
		arst_n      = 1'b0;
		cfg_valid   = 1'b0;
		cfg_index   = CFG_SCREEN_WIDTH;
		cfg_data    = '0;
		in_valid    = 1'b0;
		mode        = MODE_FRAME;
		button_key  = '0;
		rect_x      = '0;
		rect_y      = '0;
		rect_width  = '0;
		rect_height = '0;
		point_x     = '0;
		point_y     = '0;
		out_stall   = 1'b0;
		scr_w       = SCR_W_RST;
		scr_h       = SCR_H_RST;
		n_entries   = 0;
		for (int i = 0; i < MAX_BTN; i++) begin
			btn_active[i]  = 1'b0;
			btn_latched[i] = 1'b0;
		end
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		idle_en <= 1'b1;
		test_empty_table();
		test_place_and_release();
		test_screen_sizes();
		test_random_traffic(900);
		test_table_full();
		drain();
		repeat (150) @(posedge clk);
		if (err_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
